/* src/slbs_pkg.sv */
// shared types and constants for the status led blink sequencer
// no dependencies
package slbs_pkg;

  localparam int unsigned PERIOD_W = 15;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned NOW_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBCODE_STEP = 2'd3;

  localparam logic [PERIOD_W-1:0] IDLE_STEP_RST    = 15'd100;
  localparam logic [PERIOD_W-1:0] FAULT_STEP_RST   = 15'd200;
  localparam logic [PERIOD_W-1:0] POWER_STEP_RST   = 15'd100;
  localparam logic [PERIOD_W-1:0] SUBCODE_STEP_RST = 15'd1000;

  // remote display pattern codes
  typedef enum logic [2:0] {
    REM_PLC_LOCK  = 3'd0,
    REM_ALARM     = 3'd1,
    REM_BOOT_LOCK = 3'd2,
    REM_POWER     = 3'd3,
    REM_POWER_WRN = 3'd4,
    REM_IDLE      = 3'd5,
    REM_IDLE_WRN  = 3'd6
  } remote_e;

  // per-request control from status select to timer and store
  typedef struct packed {
    logic                act;
    logic [IDX_W-1:0]    len;
    logic [PERIOD_W-1:0] period;
    remote_e             sel;
  } slbs_ctrl_t;

endpackage

/* src/status_led_blink_sequencer.sv */
// status led blink sequencer top level: request register, result register, config
// depends on slbs_pkg, slbs_status, slbs_step, slbs_slots
//
// One request per tick gives exactly one result. A request is registered on
// entry and its result is computed combinationally from it into the output register, so
// a new request is taken every clock while the output is not stalled; the
// result moves from the request register into the output register and is held
// there while the output is stalled. The pattern store, slot index
// and step deadline are updated as each request moves into the output register,
// which sets the one-request-per-cycle rate. The user must write step periods
// through the config port only while no request is in flight; the block does not enforce it.
module status_led_blink_sequencer import slbs_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 10,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PERIOD_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [NOW_W-1:0]     now_ms_i,
  input  logic [31:0]          alarm_bits_i,
  input  logic [31:0]          alarm_subcode_i,
  input  logic [31:0]          warning_bits_i,
  input  logic                 plc_reload_lock_i,
  input  logic                 boot_error_lock_i,
  input  logic                 power_on_i,
  input  logic                 diag_button_i,
  input  logic                 diag_mode_i,
  input  logic                 packet_seen_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           led_code_o,
  output logic [2:0]           remote_pattern_o,
  output logic                 packet_taken_o
);

  logic [PERIOD_W-1:0] idle_step_q, fault_step_q, power_step_q, subcode_step_q;

  logic             req_valid_q;
  logic [NOW_W-1:0] now_q;
  logic [31:0]      alarm_q, sub_q, warn_q;
  logic             plc_q, boot_q, power_q, button_q, diag_q, packet_q;

  logic       out_valid_q;
  logic [7:0] led_q;
  remote_e    remote_q;
  logic       taken_q;

  logic                       advance, req_ready;
  slbs_ctrl_t                 ctrl;
  logic [SLOT_COUNT-1:0]      wr_en;
  logic [SLOT_COUNT-1:0][7:0] wr_val;
  logic [IDX_W-1:0]           idx;
  logic [7:0]                 led;
  logic                       taken;

  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign req_ready  = !req_valid_q || advance;
  assign in_stall_o = !req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_step_q    <= IDLE_STEP_RST;
      fault_step_q   <= FAULT_STEP_RST;
      power_step_q   <= POWER_STEP_RST;
      subcode_step_q <= SUBCODE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDLE_STEP:    idle_step_q    <= cfg_data_i;
        CFG_FAULT_STEP:   fault_step_q   <= cfg_data_i;
        CFG_POWER_STEP:   power_step_q   <= cfg_data_i;
        CFG_SUBCODE_STEP: subcode_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && in_valid_i) begin
      now_q    <= now_ms_i;
      alarm_q  <= alarm_bits_i;
      sub_q    <= alarm_subcode_i;
      warn_q   <= warning_bits_i;
      plc_q    <= plc_reload_lock_i;
      boot_q   <= boot_error_lock_i;
      power_q  <= power_on_i;
      button_q <= diag_button_i;
      diag_q   <= diag_mode_i;
      packet_q <= packet_seen_i;
    end
  end

  slbs_status #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_status (
    .alarm_bits_i      (alarm_q),
    .alarm_subcode_i   (sub_q),
    .warning_bits_i    (warn_q),
    .plc_reload_lock_i (plc_q),
    .boot_error_lock_i (boot_q),
    .power_on_i        (power_q),
    .diag_button_i     (button_q),
    .idle_step_i       (idle_step_q),
    .fault_step_i      (fault_step_q),
    .power_step_i      (power_step_q),
    .subcode_step_i    (subcode_step_q),
    .ctrl_o            (ctrl),
    .wr_en_o           (wr_en),
    .wr_val_o          (wr_val)
  );

  slbs_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .now_ms_i  (now_q),
    .ctrl_i    (ctrl),
    .idx_o     (idx)
  );

  slbs_slots #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .wr_en_i        (wr_en),
    .wr_val_i       (wr_val),
    .act_i          (ctrl.act),
    .idx_i          (idx),
    .diag_mode_i    (diag_q),
    .packet_seen_i  (packet_q),
    .led_code_o     (led),
    .packet_taken_o (taken)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      led_q    <= led;
      remote_q <= ctrl.sel;
      taken_q  <= taken;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_code_o       = led_q;
  assign remote_pattern_o = remote_q;
  assign packet_taken_o   = taken_q;

endmodule

/* src/slbs_status.sv */
// status priority select and pattern generation for one request
// depends on slbs_pkg
module slbs_status import slbs_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic [31:0]                alarm_bits_i,
  input  logic [31:0]                alarm_subcode_i,
  input  logic [31:0]                warning_bits_i,
  input  logic                       plc_reload_lock_i,
  input  logic                       boot_error_lock_i,
  input  logic                       power_on_i,
  input  logic                       diag_button_i,
  input  logic [PERIOD_W-1:0]        idle_step_i,
  input  logic [PERIOD_W-1:0]        fault_step_i,
  input  logic [PERIOD_W-1:0]        power_step_i,
  input  logic [PERIOD_W-1:0]        subcode_step_i,
  output slbs_ctrl_t                 ctrl_o,
  output logic [SLOT_COUNT-1:0]      wr_en_o,
  output logic [SLOT_COUNT-1:0][7:0] wr_val_o
);

  localparam logic [7:0] PAT_ON    = 8'h01;
  localparam logic [7:0] PAT_WARN  = 8'h05;
  localparam logic [7:0] PAT_ALARM = 8'h04;
  localparam logic [7:0] PAT_BOOT1 = 8'h02;
  localparam logic [7:0] PAT_OFF   = 8'h00;

  logic       sub_nz, warn_nz, alarm_nz;
  logic       btn_sub, btn_warn;
  logic [4:0] warn_pos, alarm_pos;
  logic [7:0] warn_code, alarm_code;

  assign sub_nz   = |alarm_subcode_i;
  assign warn_nz  = |warning_bits_i;
  assign alarm_nz = |alarm_bits_i;
  assign btn_sub  = diag_button_i && sub_nz;
  assign btn_warn = diag_button_i && !sub_nz && warn_nz;

  // lowest set bit position
  always_comb begin
    warn_pos  = '0;
    alarm_pos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (warning_bits_i[i]) warn_pos = 5'(i);
      if (alarm_bits_i[i]) alarm_pos = 5'(i);
    end
  end

  assign warn_code  = {warn_pos, 3'b000};
  assign alarm_code = {alarm_pos, 3'b000};

  always_comb begin
    ctrl_o.act    = btn_sub || btn_warn;
    ctrl_o.len    = '0;
    ctrl_o.period = idle_step_i;
    wr_en_o       = '0;
    wr_val_o      = '0;

    if (plc_reload_lock_i) begin
      ctrl_o.sel = REM_PLC_LOCK;
    end else if (alarm_nz) begin
      ctrl_o.sel = REM_ALARM;
    end else if (boot_error_lock_i) begin
      ctrl_o.sel = REM_BOOT_LOCK;
    end else if (power_on_i) begin
      ctrl_o.sel = warn_nz ? REM_POWER_WRN : REM_POWER;
    end else begin
      ctrl_o.sel = warn_nz ? REM_IDLE_WRN : REM_IDLE;
    end

    if (btn_sub) begin
      ctrl_o.len    = IDX_W'(5);
      ctrl_o.period = subcode_step_i;
      for (int j = 0; j < 5; j++) begin
        wr_en_o[j] = 1'b1;
      end
      wr_val_o[0] = alarm_subcode_i[7:0];
      wr_val_o[1] = alarm_subcode_i[7:0];
      wr_val_o[2] = alarm_subcode_i[15:8];
      wr_val_o[3] = alarm_subcode_i[15:8];
      wr_val_o[4] = PAT_OFF;
    end else if (btn_warn) begin
      ctrl_o.len    = IDX_W'(2);
      ctrl_o.period = fault_step_i;
      wr_en_o[0]    = 1'b1;
      wr_en_o[1]    = 1'b1;
      wr_val_o[0]   = warn_code;
      wr_val_o[1]   = warn_code;
    end else if (plc_reload_lock_i) begin
      ctrl_o.len    = IDX_W'(2);
      ctrl_o.period = idle_step_i;
      wr_en_o[0]    = 1'b1;
      wr_en_o[1]    = 1'b1;
      wr_val_o[0]   = PAT_ON;
      wr_val_o[1]   = PAT_WARN;
    end else if (alarm_nz) begin
      ctrl_o.len    = IDX_W'(2);
      ctrl_o.period = fault_step_i;
      wr_en_o[0]    = 1'b1;
      wr_en_o[1]    = 1'b1;
      wr_val_o[0]   = alarm_code | PAT_ALARM;
      wr_val_o[1]   = alarm_code;
    end else if (boot_error_lock_i) begin
      ctrl_o.len    = IDX_W'(2);
      ctrl_o.period = fault_step_i;
      wr_en_o[0]    = 1'b1;
      wr_en_o[1]    = 1'b1;
      wr_val_o[0]   = PAT_ALARM;
      wr_val_o[1]   = PAT_BOOT1;
    end else if (power_on_i) begin
      ctrl_o.len    = IDX_W'(8);
      ctrl_o.period = power_step_i;
      for (int j = 0; j < 8; j++) begin
        wr_en_o[j] = 1'b1;
      end
      wr_val_o[0] = warn_nz ? PAT_WARN : PAT_ON;
      wr_val_o[2] = PAT_ON;
    end else begin
      ctrl_o.len    = IDX_W'(10);
      ctrl_o.period = idle_step_i;
      for (int j = 0; j < 10; j++) begin
        wr_en_o[j] = 1'b1;
      end
      wr_val_o[0] = warn_nz ? PAT_WARN : PAT_ON;
      for (int j = 1; j < 5; j++) begin
        wr_val_o[j] = PAT_ON;
      end
    end
  end

endmodule

/* src/slbs_step.sv */
// drift-free step timer and slot index
// depends on slbs_pkg
module slbs_step import slbs_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [NOW_W-1:0] now_ms_i,
  input  slbs_ctrl_t       ctrl_i,
  output logic [IDX_W-1:0] idx_o
);

  logic                  first_q, first_d;
  logic                  last_btn_q, last_btn_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TIMER_BITS-1:0] dl_q, dl_d;

  logic                  change;
  logic [TIMER_BITS-1:0] now_ext, dl_a, diff;
  logic [IDX_W-1:0]      idx_a, idx_b;

  assign now_ext = TIMER_BITS'(now_ms_i);
  assign change  = last_btn_q != ctrl_i.act;
  assign idx_a   = change ? ctrl_i.len : idx_q;
  assign dl_a    = (first_q || change) ? now_ext : dl_q;
  assign diff    = now_ext - dl_a;
  assign idx_b   = idx_a + IDX_W'(1);

  always_comb begin
    first_d    = 1'b0;
    last_btn_d = ctrl_i.act;
    idx_d      = idx_a;
    dl_d       = dl_a;
    // step is due once the deadline has been reached
    if (!diff[TIMER_BITS-1]) begin
      dl_d  = dl_a + TIMER_BITS'(ctrl_i.period);
      idx_d = (idx_b >= ctrl_i.len) ? '0 : idx_b;
    end
  end

  assign idx_o = idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      last_btn_q <= 1'b0;
      idx_q      <= '0;
      dl_q       <= '0;
    end else if (advance_i) begin
      first_q    <= first_d;
      last_btn_q <= last_btn_d;
      idx_q      <= idx_d;
      dl_q       <= dl_d;
    end
  end

endmodule

/* src/slbs_slots.sv */
// pattern slot store with bit 1 adjust and bit-reversed led output
// depends on slbs_pkg
module slbs_slots import slbs_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [SLOT_COUNT-1:0]      wr_en_i,
  input  logic [SLOT_COUNT-1:0][7:0] wr_val_i,
  input  logic                       act_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic                       diag_mode_i,
  input  logic                       packet_seen_i,
  output logic [7:0]                 led_code_o,
  output logic                       packet_taken_o
);

  logic [SLOT_COUNT-1:0][7:0] slot_q, slot_d, slot_w;
  logic [7:0]                 rd, adj, shown;
  logic                       in_range;

  assign in_range = {1'b0, idx_i} < (IDX_W + 1)'(SLOT_COUNT);

  always_comb begin
    rd = '0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      slot_w[j] = wr_en_i[j] ? wr_val_i[j] : slot_q[j];
      if (idx_i == IDX_W'(j)) rd = slot_w[j];
    end
  end

  always_comb begin
    adj = rd;
    if (diag_mode_i) begin
      adj[1] = rd[0];
    end else begin
      adj[1] = packet_seen_i;
    end
  end

  assign packet_taken_o = !act_i && !diag_mode_i && packet_seen_i;

  always_comb begin
    for (int j = 0; j < SLOT_COUNT; j++) begin
      slot_d[j] = (!act_i && idx_i == IDX_W'(j)) ? adj : slot_w[j];
    end
  end

  // slots beyond the store read as zero
  assign shown = !in_range ? 8'h00 : (act_i ? rd : adj);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      led_code_o[i] = shown[7-i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (advance_i) begin
      slot_q <= slot_d;
    end
  end

endmodule
